FILE: hw/rtl/pmpp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pmpp_pkg
// Shared types and constants of the page mode pixel plotter.
// ---------------------------------------------------------------------------
package pmpp_pkg;

   localparam int unsigned FULL_ADDR_W = 12;
   localparam int unsigned PAGE_W      = 4;

   localparam logic [7:0] CMD_PAGE   = 8'hB0;
   localparam logic [7:0] CMD_COL_HI = 8'h10;

   localparam logic [1:0] SLOT_PAGE   = 2'd0;
   localparam logic [1:0] SLOT_COL_HI = 2'd1;
   localparam logic [1:0] SLOT_COL_LO = 2'd2;
   localparam logic [1:0] SLOT_DATA   = 2'd3;

   typedef struct packed {
      logic                   en;
      logic [FULL_ADDR_W-1:0] addr;
      logic [7:0]             data;
   } pmpp_wr_type;

   typedef struct packed {
      logic                   en;
      logic [FULL_ADDR_W-1:0] addr;
   } pmpp_rd_type;

endpackage
`default_nettype wire

FILE: hw/rtl/pmpp_shadow_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pmpp_shadow_ram
// Shadow display memory: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module pmpp_shadow_ram #(
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                 clock,
   input  wire pmpp_pkg::pmpp_wr_type wr_req,
   input  wire pmpp_pkg::pmpp_rd_type rd_req,
   output logic [7:0]                rd_data
);
   import pmpp_pkg::*;

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr[ADDR_W-1:0]] <= wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/pmpp_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pmpp_ctrl
// Clearing pass, pixel read-modify-write and four-byte output sequencer.
// ---------------------------------------------------------------------------
module pmpp_ctrl #(
   parameter int unsigned PAGE_COUNT   = 8,
   parameter int unsigned COLUMN_COUNT = 128
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_column,
   input  wire logic [7:0]           req_row,
   input  wire logic                 req_color,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_is_data,
   output logic                      rsp_last,
   output pmpp_pkg::pmpp_wr_type     wr_req,
   output pmpp_pkg::pmpp_rd_type     rd_req,
   input  wire logic [7:0]           rd_data
);
   import pmpp_pkg::*;

   localparam int unsigned STORE_SIZE = PAGE_COUNT * COLUMN_COUNT;
   localparam int unsigned ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam logic [7:0]  LAST_COL   = 8'(COLUMN_COUNT - 1);
   localparam logic [7:0]  LAST_ROW   = 8'(PAGE_COUNT * 8 - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [1:0]             slot_ff, slot_in;
   logic                   fresh_ff;
   logic [PAGE_W-1:0]      page_ff;
   logic [7:0]             col_ff;
   logic [2:0]             bit_ff;
   logic                   color_ff;
   logic [FULL_ADDR_W-1:0] addr_ff;
   logic [7:0]             data_ff;

   logic [7:0]             col_sat;
   logic [7:0]             row_sat;
   logic [FULL_ADDR_W-1:0] addr_full;
   logic                   take;
   logic                   send_last;
   logic [7:0]             mask;
   logic [7:0]             new_byte;

   always_comb begin
      col_sat   = (req_column > LAST_COL) ? LAST_COL : req_column;
      row_sat   = (req_row > LAST_ROW) ? LAST_ROW : req_row;
      addr_full = FULL_ADDR_W'(row_sat[6:3]) * FULL_ADDR_W'(COLUMN_COUNT)
                  + FULL_ADDR_W'(col_sat);
   end

   assign send_last = (state_ff == ST_SEND) && (slot_ff == SLOT_DATA) && !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || send_last);
   assign take      = req_valid && !req_stall;

   assign mask     = 8'd1 << bit_ff;
   assign new_byte = color_ff ? (rd_data | mask) : (rd_data & ~mask);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      slot_in  = slot_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               state_in = ST_SEND;
               slot_in  = SLOT_PAGE;
            end
         end
         ST_SEND: begin
            if (take) begin
               slot_in = SLOT_PAGE;
            end else if (send_last) begin
               state_in = ST_IDLE;
            end else if (!rsp_stall) begin
               slot_in = slot_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         slot_ff  <= SLOT_PAGE;
         fresh_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         slot_ff  <= slot_in;
         fresh_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         page_ff  <= row_sat[6:3];
         col_ff   <= col_sat;
         bit_ff   <= row_sat[2:0];
         color_ff <= req_color;
         addr_ff  <= addr_full;
      end
      if (fresh_ff) begin
         data_ff <= new_byte;
      end
   end

   always_comb begin
      rd_req.en   = take;
      rd_req.addr = addr_full;
      if (state_ff == ST_CLEAR) begin
         wr_req.en   = 1'b1;
         wr_req.addr = FULL_ADDR_W'(clr_ff);
         wr_req.data = 8'd0;
      end else begin
         wr_req.en   = fresh_ff;
         wr_req.addr = addr_ff;
         wr_req.data = new_byte;
      end
   end

   always_comb begin
      case (slot_ff)
         SLOT_PAGE:   rsp_out_byte = CMD_PAGE | {4'd0, page_ff};
         SLOT_COL_HI: rsp_out_byte = CMD_COL_HI | {4'd0, col_ff[7:4]};
         SLOT_COL_LO: rsp_out_byte = {4'd0, col_ff[3:0]};
         default:     rsp_out_byte = data_ff;
      endcase
   end

   assign rsp_valid   = (state_ff == ST_SEND);
   assign rsp_is_data = (slot_ff == SLOT_DATA);
   assign rsp_last    = (slot_ff == SLOT_DATA);

endmodule
`default_nettype wire

FILE: hw/rtl/page_mode_pixel_plotter_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// page_mode_pixel_plotter_top
// Pixel plotter for a page-mode display with a shadow copy of its memory.
// ---------------------------------------------------------------------------
// Each pixel transaction yields four bytes: page select, high column, low
// column and the updated data byte (last, is_data set). The shadow byte is
// read on the accepting edge and written back in the next cycle, so with no
// output stall a new pixel is taken as its predecessor's data byte leaves
// and the output carries one byte per cycle. After reset a clearing pass
// writes zero to all PAGE_COUNT*COLUMN_COUNT shadow bytes, one per cycle,
// and no pixel is taken until it ends.
module page_mode_pixel_plotter_top #(
   parameter int unsigned PAGE_COUNT   = 8,
   parameter int unsigned COLUMN_COUNT = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_column,
   input  wire logic [7:0] req_row,
   input  wire logic       req_color,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_data,
   output logic            rsp_last
);
   import pmpp_pkg::*;

   pmpp_wr_type wr_req;
   pmpp_rd_type rd_req;
   logic [7:0]  rd_data;

   pmpp_ctrl #(
      .PAGE_COUNT   (PAGE_COUNT),
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_column   (req_column),
      .req_row      (req_row),
      .req_color    (req_color),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_last     (rsp_last),
      .wr_req       (wr_req),
      .rd_req       (rd_req),
      .rd_data      (rd_data)
   );

   pmpp_shadow_ram #(
      .DEPTH (PAGE_COUNT * COLUMN_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire
